/* rtl/assert_macros.svh */
// Assertion macros for the port checker of the frame length splitter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define H264FLS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every rising edge, reset included.
`define H264FLS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

/* rtl/h264fls_pkg.sv */
// Types and constants of the H.264 frame length splitter.
package h264fls_pkg;

    // Default width of the byte position counter.
    localparam int POSITION_BITS_DEF = 32;

    // Width of a reported frame length.
    localparam int LEN_BITS = 32;

    // Depth of the result buffer; it must hold the two results of one item.
    localparam int FIFO_DEPTH = 4;

    // NAL unit types that matter for frame boundaries.
    localparam logic [4:0] NAL_NONE  = 5'd0;
    localparam logic [4:0] NAL_SLICE = 5'd1;
    localparam logic [4:0] NAL_DPA   = 5'd2;
    localparam logic [4:0] NAL_IDR   = 5'd5;
    localparam logic [4:0] NAL_SEI   = 5'd6;
    localparam logic [4:0] NAL_SPS   = 5'd7;
    localparam logic [4:0] NAL_PPS   = 5'd8;

    // The NAL type sits in the low five bits of the header byte.
    localparam logic [7:0] NAL_TYPE_MASK = 8'h1f;

    // A leading one in the slice header marks a slice that starts at the first macroblock.
    localparam int SLICE_START_BIT = 7;

    // Start code bytes.
    localparam logic [7:0] SC_ZERO = 8'h00;
    localparam logic [7:0] SC_ONE  = 8'h01;

    // One result item.
    typedef struct packed {
        logic [LEN_BITS-1:0] frame_length;
        logic                is_final;
    } res_t;

    // Results of one accepted item, first result in r0.
    typedef struct packed {
        logic [1:0] cnt;
        res_t       r0;
        res_t       r1;
    } push_t;

endpackage

/* rtl/h264fls_core.sv */
// Start code detection, frame decision and length computation.
module h264fls_core #(
    parameter int POSITION_BITS = h264fls_pkg::POSITION_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  logic [7:0]         stream_byte,
    input  logic               end_of_stream,
    output h264fls_pkg::push_t push
);

    localparam logic [POSITION_BITS-1:0] POS_BACK = POSITION_BITS'(5);

    logic [7:0]               win_reg [5];
    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] fs_reg;
    logic [4:0]               prev_reg;

    logic                     start_hit;
    logic [4:0]               cur_type;
    logic                     prev_pic;
    logic                     close_type;
    logic                     close_hit;
    logic [POSITION_BITS-1:0] pos_i;
    logic [POSITION_BITS-1:0] pos_inc;
    logic [POSITION_BITS-1:0] fs_after;
    logic [POSITION_BITS-1:0] frame_diff;
    logic [POSITION_BITS-1:0] final_diff;
    logic [4:0]               prev_next;

    // A start code is tested only once six bytes have been seen.
    assign start_hit = (pos_reg >= POS_BACK)
                    && (win_reg[0] == h264fls_pkg::SC_ZERO)
                    && (win_reg[1] == h264fls_pkg::SC_ZERO)
                    && (win_reg[2] == h264fls_pkg::SC_ZERO)
                    && (win_reg[3] == h264fls_pkg::SC_ONE);

    assign cur_type = 5'(win_reg[4] & h264fls_pkg::NAL_TYPE_MASK);
    assign prev_pic = (prev_reg inside {[h264fls_pkg::NAL_SLICE:h264fls_pkg::NAL_IDR]});

    // Frame boundary decision for the NAL type behind the start code.
    always_comb
    begin
        case (cur_type)
            h264fls_pkg::NAL_SLICE, h264fls_pkg::NAL_DPA, h264fls_pkg::NAL_IDR:
            begin
                if (cur_type != prev_reg)
                    close_type = prev_pic;
                else
                    close_type = stream_byte[h264fls_pkg::SLICE_START_BIT];
            end
            h264fls_pkg::NAL_SEI, h264fls_pkg::NAL_SPS, h264fls_pkg::NAL_PPS:
            begin
                close_type = prev_pic;
            end
            default:
            begin
                close_type = 1'b0;
            end
        endcase
    end

    assign close_hit = start_hit && close_type;

    // Lengths: position of the start code and the saturated byte count.
    assign pos_i      = pos_reg - POS_BACK;
    assign pos_inc    = (pos_reg == '1) ? pos_reg : pos_reg + POSITION_BITS'(1);
    assign fs_after   = close_hit ? pos_i : fs_reg;
    assign frame_diff = pos_i - fs_reg;
    assign final_diff = pos_inc - fs_after;

    // Type zero leaves the previous type untouched.
    assign prev_next = (start_hit && (cur_type != h264fls_pkg::NAL_NONE)) ? cur_type : prev_reg;

    // Pack the results of this item, the frame result first.
    always_comb
    begin
        push.r0.frame_length = h264fls_pkg::LEN_BITS'(frame_diff);
        push.r0.is_final     = 1'b0;
        push.r1.frame_length = h264fls_pkg::LEN_BITS'(final_diff);
        push.r1.is_final     = 1'b1;
        push.cnt             = 2'd0;
        if (fire)
        begin
            if (close_hit && end_of_stream)
            begin
                push.cnt = 2'd2;
            end
            else if (close_hit)
            begin
                push.cnt = 2'd1;
            end
            else if (end_of_stream)
            begin
                push.cnt = 2'd1;
                push.r0  = push.r1;
            end
        end
    end

    // State update; the last byte of a stream returns to the reset state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 5; k++)
                win_reg[k] <= '0;
            pos_reg  <= '0;
            fs_reg   <= '0;
            prev_reg <= '0;
        end
        else if (fire)
        begin
            if (end_of_stream)
            begin
                for (int k = 0; k < 5; k++)
                    win_reg[k] <= '0;
                pos_reg  <= '0;
                fs_reg   <= '0;
                prev_reg <= '0;
            end
            else
            begin
                for (int k = 0; k < 4; k++)
                    win_reg[k] <= win_reg[k+1];
                win_reg[4] <= stream_byte;
                pos_reg    <= pos_inc;
                fs_reg     <= fs_after;
                prev_reg   <= prev_next;
            end
        end
    end

endmodule

/* rtl/h264fls_out_fifo.sv */
// Small result buffer that takes up to two results a cycle and gives one while the receiver is ready.
module h264fls_out_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  h264fls_pkg::push_t push,
    output logic               room,
    output logic               out_valid,
    input  logic               out_ready,
    output h264fls_pkg::res_t  out_res
);

    localparam int PTR_BITS = $clog2(h264fls_pkg::FIFO_DEPTH);
    localparam int CNT_BITS = $clog2(h264fls_pkg::FIFO_DEPTH + 1);

    h264fls_pkg::res_t   mem [h264fls_pkg::FIFO_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] count_next;
    logic                pop;

    // Accept a new item only while two slots are free.
    assign room      = (count_reg <= CNT_BITS'(h264fls_pkg::FIFO_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_res   = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_BITS'(push.cnt);
        rd_ptr_next = pop ? rd_ptr_reg + PTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_BITS'(push.cnt) - CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
            mem[wr_ptr_reg] <= push.r0;
        if (push.cnt == 2'd2)
            mem[wr_ptr_reg + PTR_BITS'(1)] <= push.r1;
    end

endmodule

/* rtl/h264_frame_length_splitter_top.sv */
// Top level of the H.264 Annex B frame length splitter.
//
// The slave channel takes the bitstream one byte per item; tlast marks the
// final byte of a stream. The master channel gives one item per completed
// frame: tdata is the frame length in bytes, tlast is set on the closing
// length of a stream. A frame closes at a start code whose NAL type starts
// a new picture; the decision uses the current byte and a five-byte window
// kept in the core. Throughput is one byte per cycle while the slave side
// is ready. A result is written to the buffer when its byte is accepted;
// one byte can cause two results (a frame and the closing length). Results
// pass through a four-entry buffer, and the slave side is ready while two
// entries are free, so a stalled receiver holds back input only once the
// buffer fills. Reset clears the window, the position counter, the frame
// start, the previous NAL type and the buffer; the last byte of a stream
// returns the detection state to that same reset state.
module h264_frame_length_splitter_top #(
    parameter int POSITION_BITS = h264fls_pkg::POSITION_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
    input  logic        s_axis_tlast,   // end_of_stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] frame_length
    output logic        m_axis_tlast    // is_final
);

    h264fls_pkg::push_t push;
    h264fls_pkg::res_t  out_res;
    logic               fire;

    assign fire = s_axis_tvalid && s_axis_tready;

    // Detection and length computation.
    h264fls_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .stream_byte   (s_axis_tdata),
        .end_of_stream (s_axis_tlast),
        .push          (push)
    );

    // Result buffer toward the master channel.
    h264fls_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = out_res.frame_length;
    assign m_axis_tlast = out_res.is_final;

endmodule

/* rtl/h264fls_checker.sv */
// Port level checks of the frame length splitter and their binding.
`include "assert_macros.svh"

module h264fls_port_props (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // A stalled result stays offered and unchanged.
    `H264FLS_ASSERT(a_out_hold,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid,
        "result dropped while stalled")
    `H264FLS_ASSERT(a_out_stable,
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast),
        "result changed while stalled")

    // The last byte of a stream always yields a result in the next cycle.
    `H264FLS_ASSERT(a_last_result,
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> m_axis_tvalid,
        "no result after last byte")

    // A reset edge leaves the result buffer empty.
    `H264FLS_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !m_axis_tvalid, "result offered after reset")

endmodule

bind h264_frame_length_splitter_top h264fls_port_props u_checker (.*);

/* tb/h264fls_checker.sv */
// Checker that predicts the frame lengths of the splitter and compares its result items.
module h264fls_checker #(
    parameter int POSITION_BITS = h264fls_pkg::POSITION_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] out_length,
    input  logic        out_final,
    output int          mismatches,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW_DEPTH = 5;

    // Model state: the five bytes before the current one, oldest first.
    logic [7:0]               window [WINDOW_DEPTH];
    logic [POSITION_BITS-1:0] position;
    logic [4:0]               last_nal;
    logic [POSITION_BITS-1:0] frame_origin;
    h264fls_pkg::res_t        expected_frames [$];

    task automatic clear_splitter();
        for (int k = 0; k < WINDOW_DEPTH; k++)
        begin
            window[k] = h264fls_pkg::SC_ZERO;
        end
        position = '0;
        last_nal = h264fls_pkg::NAL_NONE;
        frame_origin = '0;
    endtask

    // Advance the model by one byte and queue the frame lengths it completes.
    task automatic take_byte(input logic [7:0] b, input logic eos);
        logic [POSITION_BITS-1:0] sc_pos;
        logic [POSITION_BITS-1:0] span;
        logic [4:0]               nal;
        logic                     prev_picture;
        logic                     split;
        h264fls_pkg::res_t        r;
        prev_picture = (last_nal >= h264fls_pkg::NAL_SLICE) &&
                       (last_nal <= h264fls_pkg::NAL_IDR);
        // Reset zeros never count: a start code is only tested once the window is full.
        if (position >= POSITION_BITS'(WINDOW_DEPTH) &&
            window[0] == h264fls_pkg::SC_ZERO && window[1] == h264fls_pkg::SC_ZERO &&
            window[2] == h264fls_pkg::SC_ZERO && window[3] == h264fls_pkg::SC_ONE)
        begin
            sc_pos = position - POSITION_BITS'(WINDOW_DEPTH);
            nal = 5'(window[4] & h264fls_pkg::NAL_TYPE_MASK);
            case (nal)
                h264fls_pkg::NAL_SLICE, h264fls_pkg::NAL_DPA, h264fls_pkg::NAL_IDR:
                    split = (nal != last_nal) ? prev_picture
                                              : b[h264fls_pkg::SLICE_START_BIT];
                h264fls_pkg::NAL_SEI, h264fls_pkg::NAL_SPS, h264fls_pkg::NAL_PPS:
                    split = prev_picture;
                default:
                    split = 1'b0;
            endcase
            if (split)
            begin
                span = sc_pos - frame_origin;
                r.frame_length = h264fls_pkg::LEN_BITS'(span);
                r.is_final = 1'b0;
                expected_frames.push_back(r);
                frame_origin = sc_pos;
            end
            // An unspecified NAL type leaves the previous type alone.
            if (nal != h264fls_pkg::NAL_NONE)
                last_nal = nal;
        end

        for (int k = 0; k < WINDOW_DEPTH - 1; k++)
        begin
            window[k] = window[k + 1];
        end
        window[WINDOW_DEPTH - 1] = b;
        // The position counter saturates at its all-ones value.
        if (position != '1)
            position++;

        // The last byte closes the stream with the remaining length.
        if (eos)
        begin
            span = position - frame_origin;
            r.frame_length = h264fls_pkg::LEN_BITS'(span);
            r.is_final = 1'b1;
            expected_frames.push_back(r);
            clear_splitter();
        end
    endtask

    // Watch both channels; results leave before the bytes of the same edge are counted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_splitter();
            expected_frames.delete();
            mismatches = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_frames.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result item: expected none, got length %0d final %0b",
                             $time, out_length, out_final);
                end
                else
                begin
                    if (out_length !== expected_frames[0].frame_length ||
                        out_final !== expected_frames[0].is_final)
                    begin
                        mismatches++;
                        $display("%0t: result mismatch: expected length %0d final %0b, got length %0d final %0b",
                                 $time, expected_frames[0].frame_length,
                                 expected_frames[0].is_final, out_length, out_final);
                    end
                    void'(expected_frames.pop_front());
                end
            end
            if (in_valid && in_ready)
                take_byte(in_byte, in_last);
        end
        outstanding = expected_frames.size();
    end

endmodule

/* tb/tb_top.sv */
// Testbench top of the frame length splitter: byte stimulus, result receiver and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POS_BITS      = 16;
    localparam int RANDOM_ITEMS  = 1950;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int LONG_HOLD     = 300;
    localparam int BURST_ITEMS   = 48;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;

    int          mismatches;
    int          outstanding;
    int          cycle_count = 0;
    bit          idle_on = 1'b1;
    bit          hold_req = 1'b0;
    logic [7:0]  stream_bytes [$];

    h264_frame_length_splitter_top #(
        .POSITION_BITS(POS_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    h264fls_checker #(
        .POSITION_BITS(POS_BITS)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready),
        .in_byte(s_axis_tdata),
        .in_last(s_axis_tlast),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_length(m_axis_tdata),
        .out_final(m_axis_tlast),
        .mismatches(mismatches),
        .outstanding(outstanding)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Hard limit on the run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Offer one byte after a random gap and wait until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        int gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= eos;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    task automatic send_stream();
        foreach (stream_bytes[k])
        begin
            send_byte(stream_bytes[k], k == stream_bytes.size() - 1);
        end
    endtask

    // Build one random stream: mostly NAL units behind start codes, sometimes noise or cut short.
    task automatic build_stream();
        int         units;
        int         tail;
        int         cut;
        logic [4:0] nal;
        logic [7:0] b;
        stream_bytes.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            // Noise rich in zeros and ones, so stray start codes show up.
            repeat ($urandom_range(1, 24))
            begin
                case ($urandom_range(0, 3))
                    0, 1:    b = h264fls_pkg::SC_ZERO;
                    2:       b = h264fls_pkg::SC_ONE;
                    default: b = 8'($urandom);
                endcase
                stream_bytes.push_back(b);
            end
        end
        else
        begin
            units = $urandom_range(1, 6);
            repeat (units)
            begin
                if ($urandom_range(0, 7) == 0)
                    stream_bytes.push_back(h264fls_pkg::SC_ZERO);
                // A three-byte start code is not a boundary for this block.
                if ($urandom_range(0, 9) != 0)
                    stream_bytes.push_back(h264fls_pkg::SC_ZERO);
                stream_bytes.push_back(h264fls_pkg::SC_ZERO);
                stream_bytes.push_back(h264fls_pkg::SC_ZERO);
                stream_bytes.push_back(h264fls_pkg::SC_ONE);
                case ($urandom_range(0, 11))
                    0, 1, 2: nal = h264fls_pkg::NAL_SLICE;
                    3:       nal = h264fls_pkg::NAL_DPA;
                    4, 5:    nal = h264fls_pkg::NAL_IDR;
                    6:       nal = h264fls_pkg::NAL_SEI;
                    7:       nal = h264fls_pkg::NAL_SPS;
                    8:       nal = h264fls_pkg::NAL_PPS;
                    9:       nal = h264fls_pkg::NAL_NONE;
                    default: nal = 5'($urandom_range(0, 31));
                endcase
                stream_bytes.push_back({3'($urandom_range(0, 7)), nal});
                // First slice header byte; its top bit marks a slice that starts a picture.
                stream_bytes.push_back(8'($urandom));
                tail = $urandom_range(0, 6);
                repeat (tail) stream_bytes.push_back(8'($urandom));
            end
            // Broken streams end in the middle of a unit.
            if ($urandom_range(0, 7) == 0)
            begin
                cut = $urandom_range(1, stream_bytes.size());
                while (stream_bytes.size() > cut) void'(stream_bytes.pop_back());
            end
        end
    endtask

    // Result receiver: random stalls, plus one long hold when the sender asks for it.
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 5) : 0;
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall = LONG_HOLD;
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int  sent;
        bit  pressed;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'h00;
        s_axis_tlast = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A one-byte stream gives only the closing length.
        stream_bytes = '{8'hff};
        send_stream();
        // A stream too short for any start code to be tested.
        stream_bytes = '{h264fls_pkg::SC_ZERO, h264fls_pkg::SC_ZERO, h264fls_pkg::SC_ZERO,
                         h264fls_pkg::SC_ONE, {3'b111, h264fls_pkg::NAL_SPS}};
        send_stream();
        // IDR, skipped type, repeated IDR at a new picture, then a PPS on the last
        // byte, so that one byte gives a frame and the closing length.
        stream_bytes = '{h264fls_pkg::SC_ZERO, h264fls_pkg::SC_ZERO, h264fls_pkg::SC_ZERO,
                         h264fls_pkg::SC_ONE, {3'b011, h264fls_pkg::NAL_IDR}, 8'h88,
                         h264fls_pkg::SC_ZERO, h264fls_pkg::SC_ZERO, h264fls_pkg::SC_ZERO,
                         h264fls_pkg::SC_ONE, {3'b000, h264fls_pkg::NAL_NONE}, 8'hff,
                         h264fls_pkg::SC_ZERO, h264fls_pkg::SC_ZERO, h264fls_pkg::SC_ZERO,
                         h264fls_pkg::SC_ONE, {3'b011, h264fls_pkg::NAL_IDR}, 8'h80,
                         h264fls_pkg::SC_ZERO, h264fls_pkg::SC_ZERO, h264fls_pkg::SC_ZERO,
                         h264fls_pkg::SC_ONE, {3'b100, h264fls_pkg::NAL_PPS}, 8'hff};
        send_stream();

        // Random streams, with one burst against a long receiver hold.
        sent = 0;
        pressed = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            if (!pressed && sent >= RANDOM_ITEMS / 2)
            begin
                pressed = 1'b1;
                idle_on = 1'b0;
                hold_req = 1'b1;
                repeat (BURST_ITEMS) send_byte(8'($urandom), 1'b1);
                sent += BURST_ITEMS;
            end
            build_stream();
            send_stream();
            sent += stream_bytes.size();
        end

        // A parameter set and slices back to back, ending inside an SEI unit.
        idle_on = 1'b0;
        stream_bytes = '{h264fls_pkg::SC_ZERO, h264fls_pkg::SC_ZERO, h264fls_pkg::SC_ZERO,
                         h264fls_pkg::SC_ONE, {3'b011, h264fls_pkg::NAL_SPS}, 8'h42,
                         h264fls_pkg::SC_ZERO, h264fls_pkg::SC_ZERO, h264fls_pkg::SC_ZERO,
                         h264fls_pkg::SC_ONE, {3'b011, h264fls_pkg::NAL_IDR}, 8'h88,
                         h264fls_pkg::SC_ZERO, h264fls_pkg::SC_ZERO, h264fls_pkg::SC_ZERO,
                         h264fls_pkg::SC_ONE, {3'b010, h264fls_pkg::NAL_SLICE}, 8'h9a,
                         h264fls_pkg::SC_ZERO, h264fls_pkg::SC_ZERO, h264fls_pkg::SC_ZERO,
                         h264fls_pkg::SC_ONE, {3'b000, h264fls_pkg::NAL_SEI}, 8'h05};
        send_stream();
        s_axis_tvalid <= 1'b0;

        // Drain the remaining results and watch for stray items before the verdict.
        while (outstanding != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
